### hw/rtl/rrts_pkg.sv
// Shared constants, result codes and handshake structs of the round-robin scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int BURST_BITS_DEF = 16;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  // field widths fixed by the item formats
  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int SLICE_W = 16;
  localparam int CLOCK_W = 20;
  localparam int LEFT_W  = 5;
  localparam int BCNT_W  = 5;
  localparam int BSUM_W  = 20;
  localparam int CSUM_W  = 24;
  localparam int STAT_W  = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = ID_W + SLICE_W + 1 + CLOCK_W + LEFT_W + BCNT_W + BSUM_W + CSUM_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  localparam logic [STAT_W-1:0] ST_ADDED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RAN    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_RUN = 2'd3;

  typedef struct packed {
    logic load;    // capture input transfer, read head entry
    logic commit;  // update state, load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/rrts_ctrl.sv
// Controller of the scheduler: accept an item, then commit it once the result slot is free.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_valid,
  output logic              s_ready,
  input  rrts_pkg::dp_stat_t  stat,
  output rrts_pkg::ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no transfer is taken while reset is held
  assign s_ready    = (state == S_IDLE) && !rst;
  assign cmd.load   = s_ready && s_valid;
  assign cmd.commit = (state == S_EXEC) && stat.out_free;

endmodule

`default_nettype wire

### hw/rtl/rrts_dp.sv
// Datapath of the scheduler: task ring, counters, quantum register and result register.
`timescale 1ns / 1ps
`default_nettype none

module rrts_dp #(
  parameter int MAX_TASKS  = rrts_pkg::MAX_TASKS_DEF,
  parameter int BURST_BITS = rrts_pkg::BURST_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  rrts_pkg::ctrl_cmd_t                  cmd,
  output rrts_pkg::dp_stat_t                   stat,
  input  wire                                  in_cmd,
  input  wire  [rrts_pkg::ID_W-1:0]            in_id,
  input  wire  [rrts_pkg::BURST_W-1:0]         in_burst,
  input  wire                                  cfg_valid,
  input  wire  [15:0]                          cfg_data,
  output logic                                 m_valid,
  input  wire                                  m_ready,
  output logic [rrts_pkg::OUT_TDATA_W-1:0]     m_data,
  output logic [rrts_pkg::STAT_W-1:0]          m_user
);

  localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNTW = $clog2(MAX_TASKS + 1);
  localparam int SW   = CNTW + 1;
  localparam int RW   = BURST_BITS;
  localparam int CW   = (RW > 16) ? RW : 16;
  localparam int EW   = rrts_pkg::ID_W + RW;

  // task ring: {id, remaining}
  logic [EW-1:0] ring [MAX_TASKS];
  logic [EW-1:0] rd_q;

  logic                          cmd_r;
  logic [rrts_pkg::ID_W-1:0]     id_r;
  logic [rrts_pkg::BURST_W-1:0]  burst_r;
  logic [15:0]                   quantum;

  logic [IW-1:0]                 head;
  logic [CNTW-1:0]               count;
  logic [rrts_pkg::CLOCK_W-1:0]  clock;
  logic [rrts_pkg::BCNT_W-1:0]   bcount;
  logic [rrts_pkg::BSUM_W-1:0]   bsum;
  logic [rrts_pkg::CSUM_W-1:0]   csum;

  logic [IW-1:0]                 head_next;
  logic [CNTW-1:0]               count_next;
  logic [rrts_pkg::CLOCK_W-1:0]  clock_next;
  logic [rrts_pkg::BCNT_W-1:0]   bcount_next;
  logic [rrts_pkg::BSUM_W-1:0]   bsum_next;
  logic [rrts_pkg::CSUM_W-1:0]   csum_next;

  logic [rrts_pkg::STAT_W-1:0]   status;
  logic [rrts_pkg::ID_W-1:0]     served;
  logic [rrts_pkg::SLICE_W-1:0]  slice;
  logic                          fin;
  logic                          wr_en;
  logic [EW-1:0]                 wr_data;
  logic [IW-1:0]                 tail;

  logic                          empty;
  logic                          full;
  logic [IW-1:0]                 head_base;
  logic [RW-1:0]                 b;
  logic [RW-1:0]                 rem;
  logic                          requeue;
  logic [rrts_pkg::CLOCK_W:0]    clock_sum;
  logic [rrts_pkg::CSUM_W:0]     csum_sum;
  logic [rrts_pkg::BSUM_W:0]     bsum_sum;

  // modular add for values below twice the ring depth
  function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    begin
      r = (s >= SW'(MAX_TASKS)) ? s - SW'(MAX_TASKS) : s;
      return IW'(r);
    end
  endfunction

  assign empty     = (count == '0);
  assign full      = (count >= CNTW'(MAX_TASKS));
  assign b         = RW'(burst_r);
  assign rem       = rd_q[RW-1:0];
  assign requeue   = (CW'(rem) > CW'(quantum));
  assign head_base = (cmd_r == rrts_pkg::CMD_ADD && empty) ? '0 : head;
  assign tail      = wrap(SW'(head_base) + SW'(count));

  always_comb begin
    status      = rrts_pkg::ST_NO_RUN;
    served      = '0;
    slice       = '0;
    fin         = 1'b0;
    wr_en       = 1'b0;
    wr_data     = {rrts_pkg::ID_W'(id_r), b};
    head_next   = head;
    count_next  = count;
    clock_next  = clock;
    bcount_next = bcount;
    bsum_next   = bsum;
    csum_next   = csum;
    clock_sum   = '0;
    csum_sum    = '0;
    bsum_sum    = '0;
    if (cmd_r == rrts_pkg::CMD_ADD) begin
      if (full) begin
        status = rrts_pkg::ST_FULL;
      end else begin
        status     = rrts_pkg::ST_ADDED;
        wr_en      = 1'b1;
        head_next  = head_base;
        count_next = count + 1'b1;
        if (empty) begin
          // first add after the queue drained opens a new batch
          clock_next  = '0;
          csum_next   = '0;
          bcount_next = rrts_pkg::BCNT_W'(1);
          bsum_next   = rrts_pkg::BSUM_W'(b);
        end else begin
          bcount_next = (bcount == '1) ? bcount : bcount + 1'b1;
          bsum_sum    = {1'b0, bsum} + (rrts_pkg::BSUM_W + 1)'(b);
          bsum_next   = bsum_sum[rrts_pkg::BSUM_W] ? '1 : bsum_sum[rrts_pkg::BSUM_W-1:0];
        end
      end
    end else if (!empty) begin
      status    = rrts_pkg::ST_RAN;
      served    = rd_q[EW-1:RW];
      head_next = wrap(SW'(head) + SW'(1));
      slice     = requeue ? quantum : rrts_pkg::SLICE_W'(rem);
      clock_sum = {1'b0, clock} + (rrts_pkg::CLOCK_W + 1)'(slice);
      clock_next = clock_sum[rrts_pkg::CLOCK_W] ? '1 : clock_sum[rrts_pkg::CLOCK_W-1:0];
      if (requeue) begin
        wr_en   = 1'b1;
        wr_data = {served, rem - RW'(quantum)};
      end else begin
        fin        = 1'b1;
        count_next = count - 1'b1;
        csum_sum   = {1'b0, csum} + (rrts_pkg::CSUM_W + 1)'(clock_next);
        csum_next  = csum_sum[rrts_pkg::CSUM_W] ? '1 : csum_sum[rrts_pkg::CSUM_W-1:0];
      end
    end
  end

  // ring memory: read head on accept, write tail on commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_q    <= ring[head];
      cmd_r   <= in_cmd;
      id_r    <= in_id;
      burst_r <= in_burst;
    end
    if (cmd.commit && wr_en) begin
      ring[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= rrts_pkg::QUANTUM_RESET;
      head    <= '0;
      count   <= '0;
      clock   <= '0;
      bcount  <= '0;
      bsum    <= '0;
      csum    <= '0;
    end else begin
      if (cfg_valid) quantum <= cfg_data;
      if (cmd.commit) begin
        head   <= head_next;
        count  <= count_next;
        clock  <= clock_next;
        bcount <= bcount_next;
        bsum   <= bsum_next;
        csum   <= csum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.commit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_user <= status;
      m_data <= {{rrts_pkg::OUT_PAD_W{1'b0}}, csum_next, bsum_next, bcount_next,
                 rrts_pkg::LEFT_W'(count_next), clock_next, fin, slice, served};
    end
  end

  assign stat.out_free = !m_valid || m_ready;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_TASKS))
    else $error("queue count beyond ring depth");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    SW'(head) < SW'(MAX_TASKS))
    else $error("head pointer outside ring");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_valid || m_ready))
    else $error("result register overwritten before transfer");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_valid)
    else $error("committed item produced no result");

  a_load_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.commit)
    else $error("load and commit in the same cycle");

endmodule

`default_nettype wire

### hw/rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler with a programmable quantum.
//
// Items arrive on the s_axis stream: tuser is the command (add a task at the
// tail, or run one slice), tdata carries task id and burst. Each item gives
// exactly one result on m_axis: tuser is the status code, tdata carries the
// served id, slice length, finished flag, batch clock, queue depth, batch task
// count, burst sum and completion sum.
// An item is handled in an accept step, which takes it and reads the head entry of the task
// ring (a memory with registered read), then a commit step, which updates state and loads the
// result register; a new item is taken only after the commit step of the last one.
// m_axis_tvalid rises when the commit step has loaded the result register.
// The next item is accepted while a result still waits in the output
// register; if the receiver stalls, the following item waits at its commit
// step and s_axis_tready stays low until the result slot frees.
// cfg_* writes the quantum (reset value 10); cfg_ready is high outside reset.
// Writes are to be made only while the block is idle; the block does not enforce it.
// Reset empties the queue and clears the batch clock, counts and sums; the
// ring contents need no clearing. s_axis_tready is low while reset is held.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_scheduler #(
  parameter int MAX_TASKS  = rrts_pkg::MAX_TASKS_DEF,
  parameter int BURST_BITS = rrts_pkg::BURST_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [rrts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // task_id, burst
  input  wire                                s_axis_tuser,  // cmd
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // served_id, slice_len, finished, finish_time, tasks_left, batch_tasks,
  // burst_sum, completion_sum, zero pad
  output logic [rrts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [rrts_pkg::STAT_W-1:0]        m_axis_tuser,  // status
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [15:0]                        cfg_data
);

  rrts_pkg::ctrl_cmd_t cmd;
  rrts_pkg::dp_stat_t  stat;

  assign cfg_ready = !rst;

  rrts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rrts_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .BURST_BITS (BURST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (s_axis_tuser),
    .in_id     (s_axis_tdata[7:0]),
    .in_burst  (s_axis_tdata[23:8]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_axis_tdata),
    .m_user    (m_axis_tuser)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the round-robin task scheduler, with a scheduler predictor.
module tb_top;
  import rrts_pkg::*;

  localparam int QUEUE_DEPTH = MAX_TASKS_DEF;
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int QUIET_LIMIT = 2000;
  localparam longint unsigned CLOCK_MAX = 2**CLOCK_W - 1;
  localparam longint unsigned BCNT_MAX  = 2**BCNT_W - 1;
  localparam longint unsigned BSUM_MAX  = 2**BSUM_W - 1;
  localparam longint unsigned CSUM_MAX  = 2**CSUM_W - 1;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    task_id;
  } task_word_t;

  typedef struct {
    logic       cmd;
    task_word_t word;
  } sched_item_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [CSUM_W-1:0]    completion_sum;
    logic [BSUM_W-1:0]    burst_sum;
    logic [BCNT_W-1:0]    batch_tasks;
    logic [LEFT_W-1:0]    tasks_left;
    logic [CLOCK_W-1:0]   finish_time;
    logic                 finished;
    logic [SLICE_W-1:0]   slice_len;
    logic [ID_W-1:0]      served_id;
  } slice_word_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    slice_word_t       word;
  } slice_result_t;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = CMD_ADD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [15:0]            cfg_data = '0;

  round_robin_task_scheduler DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  sched_item_t   pending_items[$];
  slice_result_t pending_results[$];
  int            mismatches = 0;

  // scheduler state as the predictor sees it
  logic [ID_W-1:0]    ring_id   [QUEUE_DEPTH];
  logic [BURST_W-1:0] ring_left [QUEUE_DEPTH];
  int                 ring_head = 0;
  int                 ring_count = 0;
  logic [15:0]        slice_quantum = QUANTUM_RESET;
  logic [CLOCK_W-1:0] batch_time = '0;
  logic [BCNT_W-1:0]  batch_adds = '0;
  logic [BSUM_W-1:0]  batch_burst_total = '0;
  logic [CSUM_W-1:0]  batch_done_total = '0;

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned limit);
    return (a + b > limit) ? limit : a + b;
  endfunction

  function automatic slice_result_t predict_slice(sched_item_t it);
    slice_result_t r;
    int tail;
    logic [BURST_W-1:0] left;
    r.status = ST_ADDED;
    r.word = '0;
    if (it.cmd == CMD_ADD) begin
      if (ring_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // first add into an empty queue opens a new batch
        if (ring_count == 0) begin
          batch_time = '0;
          batch_adds = '0;
          batch_burst_total = '0;
          batch_done_total = '0;
          ring_head = 0;
        end
        tail = (ring_head + ring_count) % QUEUE_DEPTH;
        ring_id[QIW'(tail)] = it.word.task_id;
        ring_left[QIW'(tail)] = it.word.burst;
        ring_count++;
        batch_adds = BCNT_W'(sat_add(batch_adds, 1, BCNT_MAX));
        batch_burst_total = BSUM_W'(sat_add(batch_burst_total, it.word.burst, BSUM_MAX));
      end
    end else if (ring_count == 0) begin
      r.status = ST_NO_RUN;
    end else begin
      left = ring_left[QIW'(ring_head)];
      r.status = ST_RAN;
      r.word.served_id = ring_id[QIW'(ring_head)];
      ring_head = (ring_head + 1) % QUEUE_DEPTH;
      ring_count--;
      if (left > slice_quantum) begin
        tail = (ring_head + ring_count) % QUEUE_DEPTH;
        r.word.slice_len = slice_quantum;
        batch_time = CLOCK_W'(sat_add(batch_time, slice_quantum, CLOCK_MAX));
        ring_id[QIW'(tail)] = r.word.served_id;
        ring_left[QIW'(tail)] = left - slice_quantum;
        ring_count++;
      end else begin
        r.word.slice_len = left;
        batch_time = CLOCK_W'(sat_add(batch_time, left, CLOCK_MAX));
        batch_done_total = CSUM_W'(sat_add(batch_done_total, batch_time, CSUM_MAX));
        r.word.finished = 1'b1;
      end
    end
    r.word.finish_time = batch_time;
    r.word.tasks_left = LEFT_W'(ring_count);
    r.word.batch_tasks = batch_adds;
    r.word.burst_sum = batch_burst_total;
    r.word.completion_sum = batch_done_total;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver: bursts of transfers with random gaps
  sched_item_t drive_item;
  int          run_left = 1;
  int          gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        drive_item = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= drive_item.cmd;
        s_axis_tdata <= drive_item.word;
        if (run_left > 1) begin
          run_left--;
        end else begin
          run_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver back-pressure, switching between stall styles
  rx_mode_t   stall_mode = RX_ALWAYS;
  int         mode_left = 0;
  int         stall_phase = 0;
  logic [7:0] stall_pattern = 8'hFF;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 200);
        stall_pattern = 8'($urandom) | 8'h01;
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_MOSTLY:  m_axis_tready <= ($urandom_range(0, 9) < 7);
        RX_PATTERN: m_axis_tready <= stall_pattern[3'(stall_phase)];
        default:    m_axis_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // monitor and scoreboard
  sched_item_t seen_item;

  always @(posedge clk) begin
    slice_result_t want;
    slice_word_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        slice_quantum = cfg_data;
      end
      // results first, so a transfer in the same cycle never matches itself
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0h data %0h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("served_id", want.word.served_id, got.served_id);
          check_field("slice_len", want.word.slice_len, got.slice_len);
          check_field("finished", want.word.finished, got.finished);
          check_field("finish_time", want.word.finish_time, got.finish_time);
          check_field("tasks_left", want.word.tasks_left, got.tasks_left);
          check_field("batch_tasks", want.word.batch_tasks, got.batch_tasks);
          check_field("burst_sum", want.word.burst_sum, got.burst_sum);
          check_field("completion_sum", want.word.completion_sum, got.completion_sum);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.cmd = s_axis_tuser;
        seen_item.word = s_axis_tdata;
        pending_results.push_back(predict_slice(seen_item));
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(logic cmd, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
    sched_item_t it;
    it.cmd = cmd;
    it.word.task_id = id;
    it.word.burst = burst;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(int count, int add_pct, int burst_hi);
    logic [BURST_W-1:0] burst;
    repeat (count) begin
      case ($urandom_range(0, 19))
        0:       burst = '0;
        1:       burst = '1;
        default: burst = BURST_W'($urandom_range(0, burst_hi));
      endcase
      queue_item(($urandom_range(1, 100) <= add_pct) ? CMD_ADD : CMD_RUN,
                 ID_W'($urandom_range(0, 255)), burst);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum(logic [15:0] q);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= q;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int i;
    // directed: empty run, edge bursts, slice at and past the quantum, then fill to full
    queue_item(CMD_RUN, 8'h00, 16'h0000);
    queue_item(CMD_ADD, 8'h00, 16'h0000);
    queue_item(CMD_ADD, 8'hFF, 16'hFFFF);
    queue_item(CMD_ADD, 8'hA5, 16'd10);
    queue_item(CMD_ADD, 8'h5A, 16'd11);
    repeat (4) queue_item(CMD_RUN, 8'hFF, 16'hFFFF);
    for (i = 1; i <= 14; i++) queue_item(CMD_ADD, ID_W'(i), BURST_W'(i * 1021));
    queue_item(CMD_ADD, 8'h80, 16'd1234);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    write_quantum(16'hFFFF);
    queue_random(120, 30, 65535);
    wait_idle();

    // zero quantum: unfinished tasks rotate without progress
    write_quantum(16'h0000);
    queue_random(40, 50, 0);
    wait_idle();

    // drain, then keep one long batch busy so every sum saturates
    write_quantum(16'hFFFF);
    repeat (QUEUE_DEPTH + 1) queue_item(CMD_RUN, ID_W'($urandom_range(0, 255)), '0);
    repeat (QUEUE_DEPTH) queue_item(CMD_ADD, ID_W'($urandom_range(0, 255)), 16'hFFFF);
    repeat (40) begin
      queue_item(CMD_RUN, ID_W'($urandom_range(0, 255)), BURST_W'($urandom_range(0, 65535)));
      queue_item(CMD_ADD, ID_W'($urandom_range(0, 255)), 16'hFFFF);
    end
    wait_idle();

    write_quantum(16'd1);
    queue_random(150, 55, 4);
    wait_idle();

    write_quantum(16'($urandom_range(1, 65535)));
    queue_random(150, 50, 65535);
    wait_idle();

    write_quantum(16'd10);
    queue_random(150, 70, 40);
    wait_idle();

    write_quantum(16'd3);
    queue_random(150, 35, 12);
    wait_idle();

    write_quantum(16'($urandom_range(2, 30)));
    queue_random(150, 55, 100);
    wait_idle();

    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### round_robin_task_scheduler.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/rrts_dp.sv
hw/rtl/round_robin_task_scheduler.sv
tb/tb_top.sv
